[hw/rtl/kfh_pkg.sv]
package kfh_pkg;

    localparam int NUM_BINS_DEF   = 40;
    localparam int MAX_DIGITS_DEF = 3;
    localparam int MID_DEPTH      = 4;
    localparam int OUT_DEPTH      = 4;

    localparam int KEY_LEN = 11;

    localparam logic [7:0] NEWLINE     = 8'd10;
    localparam logic [7:0] DELIM_RESET = 8'd44;
    localparam logic [7:0] DIGIT_ZERO  = 8'h30;
    localparam logic [7:0] DIGIT_NINE  = 8'h39;
    localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;

    // "category": including both quotes and the colon
    localparam logic [7:0] KEY_PATTERN [KEY_LEN] = '{
        8'h22, 8'h63, 8'h61, 8'h74, 8'h65, 8'h67, 8'h6F, 8'h72, 8'h79, 8'h22, 8'h3A
    };

    // prefix table of the key: where a partial match falls back to
    localparam logic [3:0] KEY_FALLBACK [KEY_LEN] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd0
    };

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } item_t;

    typedef struct packed {
        logic [9:0]  line_value;
        logic        key_found;
        logic        was_counted;
        logic [31:0] bin_count;
        logic [31:0] lines_seen;
    } result_t;

    // one closed line, handed from the parser to the bin updater
    typedef struct packed {
        logic [9:0] value;
        logic       found;
        logic       countable;
    } line_rec_t;

    // Advance the streaming key matcher by one byte. The fallback table of
    // this key never chains more than twice, so three steps cover it.
    function automatic logic [3:0] key_advance(input logic [3:0] pos, input logic [7:0] b);
        logic [3:0] p;
        p = pos;
        for (int i = 0; i < 3; i++) begin
            if (p != 4'd0 && KEY_PATTERN[p] != b) begin
                p = KEY_FALLBACK[p - 4'd1];
            end
        end
        if (KEY_PATTERN[p] == b) begin
            p = p + 4'd1;
        end
        return p;
    endfunction

endpackage

[hw/rtl/kfh_ram.sv]
module kfh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 40
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/kfh_fifo.sv]
module kfh_fifo #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic [WIDTH-1:0]               wdata,
    input  logic                           pop,
    output logic [WIDTH-1:0]               rdata,
    output logic                           full,
    output logic                           empty,
    output logic [$clog2(DEPTH+1)-1:0]     count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = slot_reg[rd_ptr_reg];
    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

[hw/rtl/kfh_front.sv]
module kfh_front #(
    parameter int NUM_BINS   = 40,
    parameter int MAX_DIGITS = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  kfh_pkg::item_t    item,
    input  logic              take,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_data,
    output kfh_pkg::line_rec_t rec,
    output logic              rec_push
);
    import kfh_pkg::*;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    phase_t     phase_reg, phase_next, t_phase;
    logic [3:0] pos_reg, pos_next, t_pos, adv_pos;
    logic [9:0] acc_reg, acc_next, t_acc;
    logic [1:0] dig_reg, dig_next, t_dig;
    logic       bad_reg, bad_next, t_bad;
    logic [7:0] delim_reg;
    logic [7:0] b;
    logic       nl;
    logic       close;

    always_comb
    begin
        b       = item.text_byte;
        nl      = (b == NEWLINE);
        close   = take && (nl || item.final_byte);
        adv_pos = key_advance(pos_reg, b);

        t_phase = phase_reg;
        t_pos   = pos_reg;
        t_acc   = acc_reg;
        t_dig   = dig_reg;
        t_bad   = bad_reg;

        // a newline is never parsed as text
        if (!nl)
        begin
            case (phase_reg)
                PH_SEARCH:
                begin
                    if (adv_pos == 4'(KEY_LEN))
                    begin
                        t_pos   = '0;
                        t_phase = PH_DIGITS;
                    end
                    else
                    begin
                        t_pos = adv_pos;
                    end
                end
                PH_DIGITS:
                begin
                    if (b == delim_reg)
                    begin
                        t_phase = PH_DONE;
                    end
                    else if (b inside {[DIGIT_ZERO:DIGIT_NINE]} && dig_reg < 2'(MAX_DIGITS))
                    begin
                        t_acc = acc_reg * 10'd10 + {6'd0, b[3:0]};
                        t_dig = dig_reg + 2'd1;
                    end
                    else
                    begin
                        t_bad = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        rec.found     = (t_phase == PH_DONE);
        rec.value     = rec.found ? t_acc : '0;
        rec.countable = rec.found && !t_bad && (t_dig != 2'd0)
                        && ({1'b0, rec.value} < 11'(NUM_BINS));
        rec_push      = close;

        if (close)
        begin
            phase_next = PH_SEARCH;
            pos_next   = '0;
            acc_next   = '0;
            dig_next   = '0;
            bad_next   = 1'b0;
        end
        else if (take)
        begin
            phase_next = t_phase;
            pos_next   = t_pos;
            acc_next   = t_acc;
            dig_next   = t_dig;
            bad_next   = t_bad;
        end
        else
        begin
            phase_next = phase_reg;
            pos_next   = pos_reg;
            acc_next   = acc_reg;
            dig_next   = dig_reg;
            bad_next   = bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEARCH;
            pos_reg   <= '0;
            acc_reg   <= '0;
            dig_reg   <= '0;
            bad_reg   <= 1'b0;
            delim_reg <= DELIM_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            dig_reg   <= dig_next;
            bad_reg   <= bad_next;
            if (cfg_we)
            begin
                delim_reg <= cfg_data;
            end
        end
    end

    a_pos_in_key: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < 4'(KEY_LEN))
        else $error("key match position ran past the key");

    a_clear_after_close: assert property (@(posedge clk) disable iff (!rst_n)
        rec_push |=> (pos_reg == '0 && phase_reg == PH_SEARCH && dig_reg == '0 && !bad_reg))
        else $error("line state not cleared after a closed line");

    a_digit_limit: assert property (@(posedge clk) disable iff (!rst_n)
        dig_reg <= 2'(MAX_DIGITS))
        else $error("more digits taken than allowed");

endmodule

[hw/rtl/kfh_back.sv]
module kfh_back #(
    parameter int NUM_BINS = 40
) (
    input  logic               clk,
    input  logic               rst_n,
    input  kfh_pkg::line_rec_t rec,
    input  logic               rec_avail,
    output logic               rec_take,
    output logic               clearing,
    input  logic               pop,
    output kfh_pkg::result_t   result,
    output logic               empty
);
    import kfh_pkg::*;

    localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int OCW   = $clog2(OUT_DEPTH + 1);

    logic             clearing_reg, clearing_next;
    logic [BIN_W-1:0] clr_idx_reg, clr_idx_next;

    logic             issue;
    logic             s1_valid_reg;
    line_rec_t        s1_rec_reg;
    logic [BIN_W-1:0] s1_addr;

    logic             fwd_valid_reg;
    logic [BIN_W-1:0] fwd_addr_reg;
    logic [31:0]      fwd_data_reg;

    logic [31:0]      rd_data, old_count, new_count;
    logic             wr_upd, ram_we;
    logic [BIN_W-1:0] ram_waddr;
    logic [31:0]      ram_wdata;

    logic [31:0]      lines_reg, lines_next;

    result_t          out_data;
    logic             out_full;
    logic [OCW-1:0]   out_count;
    logic [$bits(result_t)-1:0] out_rdata;

    // issue only while the result queue has room for everything in flight
    assign issue    = rec_avail && !clearing_reg
                      && (({1'b0, out_count} + (OCW+1)'(s1_valid_reg)) < (OCW+1)'(OUT_DEPTH));
    assign rec_take = issue;
    assign s1_addr  = s1_rec_reg.value[BIN_W-1:0];

    always_comb
    begin
        old_count = (fwd_valid_reg && fwd_addr_reg == s1_addr) ? fwd_data_reg : rd_data;
        new_count = (old_count == COUNT_MAX) ? old_count : old_count + 32'd1;
        wr_upd    = s1_valid_reg && s1_rec_reg.countable;

        ram_we    = clearing_reg || wr_upd;
        ram_waddr = clearing_reg ? clr_idx_reg : s1_addr;
        ram_wdata = clearing_reg ? '0 : new_count;

        clearing_next = clearing_reg && (clr_idx_reg != BIN_W'(NUM_BINS - 1));
        clr_idx_next  = clearing_reg ? clr_idx_reg + BIN_W'(1) : clr_idx_reg;

        lines_next = lines_reg;
        if (s1_valid_reg && lines_reg != COUNT_MAX)
        begin
            lines_next = lines_reg + 32'd1;
        end

        out_data.line_value  = s1_rec_reg.value;
        out_data.key_found   = s1_rec_reg.found;
        out_data.was_counted = s1_rec_reg.countable;
        out_data.bin_count   = s1_rec_reg.countable ? new_count : '0;
        out_data.lines_seen  = lines_next;
    end

    kfh_ram #(
        .WIDTH (32),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue && rec.countable),
        .raddr (rec.value[BIN_W-1:0]),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            lines_reg     <= '0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_idx_reg   <= clr_idx_next;
            s1_valid_reg  <= issue;
            fwd_valid_reg <= wr_upd;
            lines_reg     <= lines_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_rec_reg <= rec;
        end
        if (wr_upd)
        begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= new_count;
        end
    end

    kfh_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (s1_valid_reg),
        .wdata (out_data),
        .pop   (pop && !empty),
        .rdata (out_rdata),
        .full  (out_full),
        .empty (empty),
        .count (out_count)
    );

    assign result   = result_t'(out_rdata);
    assign clearing = clearing_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_valid_reg && out_full && !(pop && !empty)))
        else $error("result queue written while full");

    a_no_issue_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !issue)
        else $error("line issued during bin clearing");

    a_counted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        wr_upd |-> new_count != '0)
        else $error("counted line left its bin at zero");

endmodule

[hw/rtl/keyed_field_histogram_unit.sv]
// Keyed field histogram: text enters one byte per request through push/full,
// at up to one byte every clock. Each line is scanned for the first
// "category": key, the decimal value after it is read up to the delimiter
// byte (configurable, comma after reset), and at a newline or a byte marked
// final one result leaves through the empty/pop queue: the value, whether the
// key and delimiter were seen, whether the value was counted, the bin's new
// saturating count and the saturating line total. The parser front end takes
// a byte every cycle while full is low; closed lines wait in a four-entry
// queue for the bin updater, which handles one line per cycle while the result
// queue has room, with a read-modify-write of the bin memory (registered read,
// write in the following cycle, last write forwarded). Results drain into a
// four-entry queue, so the input keeps flowing while a result waits to be
// popped; full rises only when that backlog reaches the line queue. After
// reset the bin memory is cleared bin by bin, during which full
// stays high; the delimiter may be written then or whenever the block is idle.
module keyed_field_histogram_unit #(
    parameter int NUM_BINS   = kfh_pkg::NUM_BINS_DEF,
    parameter int MAX_DIGITS = kfh_pkg::MAX_DIGITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    // text byte requests
    input  logic             push,
    input  kfh_pkg::item_t   item,
    output logic             full,
    // result requests
    output logic             empty,
    input  logic             pop,
    output kfh_pkg::result_t result,
    // delimiter register writes
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [7:0]       cfg_data
);
    import kfh_pkg::*;

    line_rec_t front_rec, mid_rec;
    logic      front_push;
    logic      mid_full, mid_empty, mid_pop;
    logic      clearing;
    logic      take;
    logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
    logic [$bits(line_rec_t)-1:0]   mid_rdata;

    // hold off new bytes while the bins clear or the line queue is full
    assign full      = mid_full || clearing;
    assign take      = push && !full;
    assign cfg_ready = 1'b1;

    kfh_front #(
        .NUM_BINS   (NUM_BINS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .take     (take),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .rec      (front_rec),
        .rec_push (front_push)
    );

    // closed lines wait here so parser and bin updater stall independently
    kfh_fifo #(
        .WIDTH ($bits(line_rec_t)),
        .DEPTH (MID_DEPTH)
    ) u_line_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .wdata (front_rec),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .full  (mid_full),
        .empty (mid_empty),
        .count (mid_count)
    );

    assign mid_rec = line_rec_t'(mid_rdata);

    kfh_back #(
        .NUM_BINS (NUM_BINS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec       (mid_rec),
        .rec_avail (!mid_empty),
        .rec_take  (mid_pop),
        .clearing  (clearing),
        .pop       (pop),
        .result    (result),
        .empty     (empty)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mid_count <= ($clog2(MID_DEPTH+1))'(MID_DEPTH))
        else $error("line queue count out of range");

    a_no_line_loss: assert property (@(posedge clk) disable iff (!rst_n)
        front_push |-> !mid_full)
        else $error("closed line pushed into a full line queue");

    a_quiet_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (mid_empty && empty))
        else $error("work pending during bin clearing");

endmodule

[verif/tb_top.sv]
module tb_top;
    import kfh_pkg::*;

    localparam int          NUM_BINS      = NUM_BINS_DEF;
    localparam int          MAX_DIGITS    = MAX_DIGITS_DEF;
    // the key as one word, first character in the top byte
    localparam logic [87:0] CATEGORY_KEY  = "\"category\":";
    localparam logic [7:0]  SEMICOLON     = 8'h3B;
    localparam logic [7:0]  STRAY_LETTER  = 8'h78;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          CYCLE_LIMIT   = 600000;
    localparam int          REPORT_LIMIT  = 10;
    localparam int          CHUNKS        = 7;
    localparam int          STALL_CHUNK   = 3;

    typedef enum logic [1:0] {SEEK_KEY, READ_VALUE, VALUE_CLOSED} scan_phase_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       push      = 1'b0;
    item_t      item      = '0;
    logic       full;
    logic       empty;
    logic       pop       = 1'b0;
    result_t    result;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = '0;

    keyed_field_histogram_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Text requests waiting to be offered, and line results owed by the block.
    item_t       text_queue [$];
    result_t     line_reports_due [$];

    // Shadow of the parser and the histogram.
    logic [7:0]  field_delim  = DELIM_RESET;
    scan_phase_t scan_phase   = SEEK_KEY;
    logic [87:0] key_window   = '0;
    int unsigned key_fill     = 0;
    logic [9:0]  digit_value  = '0;
    int unsigned digit_count  = 0;
    logic        value_broken = 1'b0;
    logic [31:0] bin_counts [NUM_BINS];
    logic [31:0] line_total   = '0;

    int unsigned send_gap     = 0;
    int unsigned send_calm    = 0;
    int unsigned pop_gap      = 0;
    int unsigned pop_calm     = 0;
    int unsigned hold_left    = 0;
    logic        hold_arm     = 1'b0;
    logic        hold_done    = 1'b0;
    int unsigned bad_reports  = 0;
    int unsigned cycle_count  = 0;
    result_t     want_result;
    logic        field_bad;

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Forget everything about the current line.
    function automatic void restart_line();
        scan_phase   = SEEK_KEY;
        key_window   = '0;
        key_fill     = 0;
        digit_value  = '0;
        digit_count  = 0;
        value_broken = 1'b0;
    endfunction

    // Advance the shadow parser by one accepted text byte; when the byte
    // closes a line, append the result the block owes for it.
    function automatic void parse_text_byte(input item_t req);
        result_t    report;
        logic [7:0] b;
        logic       closes;
        b      = req.text_byte;
        closes = (b == NEWLINE) || req.final_byte;
        if (b != NEWLINE)
        begin
            case (scan_phase)
                SEEK_KEY:
                begin
                    // Compare a sliding window against the key: the first
                    // full match wins, overlapping starts included.
                    key_window = {key_window[79:0], b};
                    if (key_fill < KEY_LEN)
                        key_fill++;
                    if (key_fill == KEY_LEN && key_window == CATEGORY_KEY)
                        scan_phase = READ_VALUE;
                end
                READ_VALUE:
                begin
                    if (b == field_delim)
                        scan_phase = VALUE_CLOSED;
                    else if (b >= DIGIT_ZERO && b <= DIGIT_NINE && digit_count < MAX_DIGITS)
                    begin
                        digit_value = 10'(digit_value * 10 + (b - DIGIT_ZERO));
                        digit_count++;
                    end
                    else
                        value_broken = 1'b1;
                end
                default: ;
            endcase
        end
        if (closes)
        begin
            report             = '0;
            report.key_found   = (scan_phase == VALUE_CLOSED);
            if (report.key_found)
                report.line_value = digit_value;
            report.was_counted = report.key_found && !value_broken && digit_count > 0
                                 && digit_value < NUM_BINS;
            if (report.was_counted)
            begin
                if (bin_counts[digit_value] != COUNT_MAX)
                    bin_counts[digit_value]++;
                report.bin_count = bin_counts[digit_value];
            end
            if (line_total != COUNT_MAX)
                line_total++;
            report.lines_seen = line_total;
            line_reports_due.push_back(report);
            restart_line();
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    function automatic void add_byte(input logic [7:0] b, input logic fin);
        item_t req;
        req.text_byte  = b;
        req.final_byte = fin;
        text_queue.push_back(req);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], 1'b0);
    endfunction

    // Any byte but a newline, so the line stays whole.
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == NEWLINE);
        return b;
    endfunction

    // Mostly values that land in a bin; some with leading zeros, some too big.
    function automatic string value_text();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return $sformatf("%0d", $urandom_range(0, NUM_BINS - 1));
        if (pick == 7)
            return $sformatf("%03d", $urandom_range(0, NUM_BINS - 1));
        return $sformatf("%0d", $urandom_range(NUM_BINS, 999));
    endfunction

    // End a line: usually a plain newline, now and then a byte marked final.
    function automatic void close_line();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            add_byte(noise_byte(), 1'b1);
        else if (r == 1)
            add_byte(NEWLINE, 1'b1);
        else
            add_byte(NEWLINE, 1'b0);
    endfunction

    // One random line for the current delimiter: most carry the key and a
    // value, the rest are broken in one of the ways the parser must flag.
    function automatic void random_line();
        int unsigned kind;
        int unsigned shape;
        int unsigned tail;
        kind = $urandom_range(0, 99);
        repeat ($urandom_range(0, 4))
            add_byte(noise_byte(), 1'b0);
        if (kind < 6)
        begin
            // raw bytes, newlines included, so lines split anywhere
            repeat ($urandom_range(1, 24))
                add_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        else if (kind < 12)
        begin
            add_text("\"categor");
            repeat ($urandom_range(0, 6))
                add_byte(noise_byte(), 1'b0);
        end
        else
        begin
            // lead in with a partial key so the matcher has to fall back
            if (kind < 24)
            begin
                case ($urandom_range(0, 2))
                    0:       add_text("\"");
                    1:       add_text("\"category\"");
                    default: add_text("\"cat");
                endcase
            end
            add_text("\"category\":");
            shape = $urandom_range(0, 99);
            if (shape < 65)
                add_text(value_text());
            else if (shape < 72)
            begin
                repeat ($urandom_range(4, 6))
                    add_byte(8'(DIGIT_ZERO + $urandom_range(0, 9)), 1'b0);
            end
            else if (shape < 79)
            begin
                add_text(value_text());
                add_byte(($urandom_range(0, 1) != 0) ? STRAY_LETTER : noise_byte(), 1'b0);
            end
            else if (shape >= 85 && shape < 93)
                add_text(value_text());
            // lines with a shape from 85 to 92 close before the delimiter
            if (shape < 85 || shape >= 93)
            begin
                add_byte(field_delim, 1'b0);
                tail = $urandom_range(0, 99);
                if (tail < 15)
                begin
                    add_text("\"category\":9");
                    add_byte(field_delim, 1'b0);
                end
                else if (tail < 60)
                begin
                    repeat ($urandom_range(1, 5))
                        add_byte(noise_byte(), 1'b0);
                end
            end
        end
        close_line();
    endfunction

    function automatic logic [7:0] pick_delimiter();
        logic [7:0] d;
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return DELIM_RESET;
            3:       return SEMICOLON;
            default: ;
        endcase
        do
            d = 8'($urandom_range(0, 255));
        while (d == NEWLINE || (d >= DIGIT_ZERO && d <= DIGIT_NINE));
        return d;
    endfunction

    // Write the delimiter register and track it in the shadow.
    task automatic write_delimiter(input logic [7:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        field_delim = value;
    endtask

    // Let the sender run dry and every owed result come back, then give the
    // bin updater time to finish whatever it still holds. Check on the
    // falling edge, once the rising-edge updates have settled.
    task automatic drain();
        while (text_queue.size() != 0 || push || line_reports_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Sender: offer one text request at a time from the queue, with random
    // gaps between requests and calm stretches with none.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push      <= 1'b0;
            item      <= '0;
            send_gap  <= 0;
            send_calm <= 0;
        end
        else
        begin
            // score the request the block takes at this edge
            if (push && !full)
                parse_text_byte(item);
            // hold a refused request as it is until full drops
            if (!(push && full))
            begin
                if (send_gap != 0)
                begin
                    push     <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (text_queue.size() != 0)
                begin
                    push <= 1'b1;
                    item <= text_queue.pop_front();
                    if (send_calm != 0)
                    begin
                        send_calm <= send_calm - 1;
                        send_gap  <= 0;
                    end
                    else
                    begin
                        send_gap <= pick_gap();
                        if ($urandom_range(0, 39) == 0)
                            send_calm <= $urandom_range(20, 90);
                    end
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, armed once by the stimulus: count it down here
    // so the block backs up into full while the sender keeps offering.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_arm && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Receiver: pop results at random and compare each one with the oldest
    // owed result, field by field.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop      <= 1'b0;
            pop_gap  <= 0;
            pop_calm <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (line_reports_due.size() == 0)
                begin
                    bad_reports++;
                    if (bad_reports <= REPORT_LIMIT)
                        $display("unexpected result val=%0d key=%0b cnt=%0b bin=%0d lines=%0d",
                                 result.line_value, result.key_found, result.was_counted,
                                 result.bin_count, result.lines_seen);
                end
                else
                begin
                    want_result = line_reports_due.pop_front();
                    field_bad   = (result.line_value  !== want_result.line_value)
                               || (result.key_found   !== want_result.key_found)
                               || (result.was_counted !== want_result.was_counted)
                               || (result.bin_count   !== want_result.bin_count)
                               || (result.lines_seen  !== want_result.lines_seen);
                    if (field_bad)
                    begin
                        bad_reports++;
                        if (bad_reports <= REPORT_LIMIT)
                        begin
                            $display("mismatch want val=%0d key=%0b cnt=%0b bin=%0d lines=%0d",
                                     want_result.line_value, want_result.key_found,
                                     want_result.was_counted, want_result.bin_count,
                                     want_result.lines_seen);
                            $display("         got  val=%0d key=%0b cnt=%0b bin=%0d lines=%0d",
                                     result.line_value, result.key_found,
                                     result.was_counted, result.bin_count,
                                     result.lines_seen);
                        end
                    end
                end
            end
            if (hold_left != 0)
                pop <= 1'b0;
            else if (!pop || !empty)
            begin
                // keep pop up while nothing waits; pick a gap after each pop
                if (pop_gap != 0)
                begin
                    pop     <= 1'b0;
                    pop_gap <= pop_gap - 1;
                end
                else
                begin
                    pop <= 1'b1;
                    if (pop_calm != 0)
                    begin
                        pop_calm <= pop_calm - 1;
                        pop_gap  <= 0;
                    end
                    else
                    begin
                        pop_gap <= pick_gap();
                        if ($urandom_range(0, 29) == 0)
                            pop_calm <= $urandom_range(15, 60);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[keyed_field_histogram_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        int unsigned start_size;
        int unsigned chunk_bytes;
        foreach (bin_counts[i])
            bin_counts[i] = '0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        // The bin memory clears right after reset; write the delimiter then.
        write_delimiter(DELIM_RESET);

        // Directed lines with the comma delimiter: bin edges, value limits,
        // every way a value goes bad, split and repeated keys.
        add_text("\"category\":0,\n");
        add_text("\"category\":39,x\n");
        add_text("\"category\":40,\n");
        add_text("\"category\":999,\n");
        add_text("\"category\":1234,\n");
        add_text("\"category\":,\n");
        add_text("\"category\":1a,\n");
        add_text("\"category\":5\n");
        add_text("\"\"category\"\"category\":0,\"category\":1,\n");
        add_text("\"categ\"category\":007,\n");
        add_text("no key here\n");
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_text("\"category\":39,\n");
        // final byte closes an open line, then a final newline alone
        add_text("\"category\":7");
        add_byte(DELIM_RESET, 1'b1);
        add_byte(NEWLINE, 1'b1);
        drain();

        // Newline as delimiter: the line always ends first.
        write_delimiter(NEWLINE);
        add_text("\"category\":3\n");
        add_text("\"category\":12,\n");
        drain();

        // A digit as delimiter ends the value at that digit.
        write_delimiter(8'h35);
        add_text("\"category\":35,\n");
        add_text("\"category\":5\n");
        drain();

        write_delimiter(8'h00);
        add_text("\"category\":21");
        add_byte(8'h00, 1'b0);
        add_byte(NEWLINE, 1'b0);
        drain();

        write_delimiter(8'hFF);
        add_text("\"category\":21");
        add_byte(8'hFF, 1'b0);
        add_byte(NEWLINE, 1'b0);
        drain();

        // Random phases, each under its own delimiter; the sender pauses at
        // every phase end until all owed results are back.
        for (int chunk = 0; chunk < CHUNKS; chunk++)
        begin
            write_delimiter((chunk == 0) ? DELIM_RESET : pick_delimiter());
            chunk_bytes = (chunk == STALL_CHUNK) ? 400 : 80;
            if (chunk == STALL_CHUNK)
                hold_arm <= 1'b1;
            start_size = text_queue.size();
            while (text_queue.size() - start_size < chunk_bytes)
                random_line();
            drain();
        end

        if (bad_reports == 0 && line_reports_due.size() == 0)
            $display("[keyed_field_histogram_unit] OK");
        else
            $display("[keyed_field_histogram_unit] ERROR");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/kfh_pkg.sv
hw/rtl/kfh_ram.sv
hw/rtl/kfh_fifo.sv
hw/rtl/kfh_front.sv
hw/rtl/kfh_back.sv
hw/rtl/keyed_field_histogram_unit.sv
verif/tb_top.sv
